// ===== design/bpfa_pkg.sv =====
// Shared types and constants for the bitmap page frame allocator.
// No dependencies; imported by the allocator core and its testbench.
`default_nettype none

package bpfa_pkg;

    // Field widths of the request and response beats.
    localparam int unsigned PN_W   = 13;  // page numbers, counts, hint, page limit
    localparam int unsigned ADDR_W = 32;  // request byte address
    localparam int unsigned GA_W   = 24;  // granted byte address
    localparam int unsigned ACT_W  = 2;
    localparam int unsigned ST_W   = 3;

    // The used map is held as 32-bit words.
    localparam int unsigned MAP_BITS = 32;
    localparam int unsigned BIT_W    = 5;
    localparam int unsigned WORD_W   = PN_W - BIT_W;

    // Request action codes.
    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC   = 2'd0,
        ACT_FREE    = 2'd1,
        ACT_RESERVE = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    // Response status codes.
    typedef enum logic [ST_W-1:0] {
        STAT_DONE       = 3'd0,
        STAT_FULL       = 3'd1,
        STAT_MISALIGNED = 3'd2,
        STAT_RANGE      = 3'd3,
        STAT_NOCHANGE   = 3'd4
    } t_status;

endpackage

`default_nettype wire

// ===== design/bpfa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module bpfa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                      i_wr_data,
    input  wire logic                                  i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/bitmap_page_frame_allocator_core.sv =====
// Allocate reads the hint word from S_IDLE and scans in S_SCAN up to the last word below the limit;
// free and reserve go through S_FR_CHK, rejected requests through S_RESP; each reply is registered.
// One request at a time: the scan walks the used map one 32-bit RAM word per cycle.
// Reset (synchronous, active low) starts a clearing pass over all MEM_WORDS map words that zeroes
// the used map; requests are held off until it ends, config writes are taken throughout.
// Depends on bpfa_pkg and bpfa_ram.
`default_nettype none

module bitmap_page_frame_allocator_core
    import bpfa_pkg::*;
#(
    parameter int unsigned FRAME_COUNT = 4096,
    parameter int unsigned PAGE_BYTES  = 4096
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // Configuration write channel.
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [PN_W-1:0]   i_pages_in_use_range,
    // Request channel.
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [ACT_W-1:0]  i_action,
    input  wire logic [ADDR_W-1:0] i_page_address,
    // Response channel.
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [GA_W-1:0]        o_granted_address,
    output logic [ST_W-1:0]        o_status,
    output logic [PN_W-1:0]        o_used_count,
    output logic [PN_W-1:0]        o_free_count
);

    // Only pages below the 13-bit page limit can ever be reached.
    localparam int unsigned MAP_WORDS_ALL = (FRAME_COUNT + MAP_BITS - 1) / MAP_BITS;
    localparam int unsigned MEM_WORDS     = MAP_WORDS_ALL > 256 ? 256 : MAP_WORDS_ALL;
    localparam int unsigned WAW           = MEM_WORDS > 1 ? $clog2(MEM_WORDS) : 1;
    localparam int unsigned PB_LOG        = $clog2(PAGE_BYTES);
    localparam logic [PN_W-1:0] LIM_CAP   = PN_W'(FRAME_COUNT > 8191 ? 8191 : FRAME_COUNT);
    localparam logic [WORD_W-1:0] LAST_MEM_WORD = WORD_W'(MEM_WORDS - 1);
    localparam logic [ADDR_W-1:0] OFS_MASK = ADDR_W'(PAGE_BYTES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FR_CHK,
        S_RESP
    } t_state;

    t_state              r_state, n_state;
    logic [WORD_W-1:0]   r_word, n_word;
    logic [PN_W-1:0]     r_used, n_used;
    logic [PN_W-1:0]     r_hint, n_hint;
    logic [PN_W-1:0]     r_cfg_pages;
    logic [PN_W-1:0]     r_page, n_page;
    logic                r_is_free, n_is_free;
    t_status             r_status, n_status;
    logic                r_out_valid, n_out_valid;
    logic [GA_W-1:0]     r_granted, n_granted;
    logic [ST_W-1:0]     r_out_status, n_out_status;
    logic [PN_W-1:0]     r_out_used, n_out_used;
    logic [PN_W-1:0]     r_out_free, n_out_free;

    // Map RAM controls.
    logic                ram_wr_en;
    logic [WAW-1:0]      ram_wr_addr;
    logic [MAP_BITS-1:0] ram_wr_data;
    logic                ram_rd_en;
    logic [WAW-1:0]      ram_rd_addr;
    logic [MAP_BITS-1:0] ram_rd_data;

    // Request decode and shared scan datapath.
    logic [PN_W-1:0]       limit;
    logic [PN_W-1:0]       limit_m1;
    logic [ADDR_W-1:0]     req_page_full;
    logic [PN_W-1:0]       req_page;
    logic                  req_misaligned;
    logic                  req_out_range;
    logic                  slot_free;
    logic [MAP_BITS-1:0]   lo_mask;
    logic [MAP_BITS-1:0]   hi_mask;
    logic [MAP_BITS-1:0]   free_bits;
    logic                  scan_found;
    logic [BIT_W-1:0]      scan_idx;
    logic [PN_W-1:0]       scan_page;
    logic [PN_W+16-1:0]    grant_wide;
    logic                  fr_bit;

    bpfa_ram #(
        .WIDTH (MAP_BITS),
        .DEPTH (MEM_WORDS)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Effective page limit and request address checks.
    assign limit          = (r_cfg_pages > LIM_CAP) ? LIM_CAP : r_cfg_pages;
    assign limit_m1       = limit - PN_W'(1);
    assign req_page_full  = i_page_address >> PB_LOG;
    assign req_page       = req_page_full[PN_W-1:0];
    assign req_misaligned = (i_page_address & OFS_MASK) != '0;
    assign req_out_range  = req_page_full >= ADDR_W'(limit);
    assign slot_free      = !r_out_valid || i_ready;

    // Mask off pages below the hint and at or above the limit, then find the first clear bit.
    assign lo_mask   = (MAP_BITS'(1) << r_hint[BIT_W-1:0]) - MAP_BITS'(1);
    assign hi_mask   = ~((MAP_BITS'(1) << limit[BIT_W-1:0]) - MAP_BITS'(1));
    assign free_bits = ~(ram_rd_data
                       | ((r_word == r_hint[PN_W-1:BIT_W]) ? lo_mask : '0)
                       | ((r_word == limit[PN_W-1:BIT_W]) ? hi_mask : '0));
    assign scan_found = |free_bits;

    always_comb begin
        scan_idx = '0;
        for (int j = MAP_BITS - 1; j >= 0; j--) begin
            if (free_bits[j]) begin
                scan_idx = BIT_W'(j);
            end
        end
    end

    assign scan_page  = {r_word, scan_idx};
    assign grant_wide = (PN_W+16)'(scan_page) << PB_LOG;
    assign fr_bit     = ram_rd_data[r_page[BIT_W-1:0]];

    // Sequencer next state, map accesses and response.
    always_comb begin
        n_state      = r_state;
        n_word       = r_word;
        n_used       = r_used;
        n_hint       = r_hint;
        n_page       = r_page;
        n_is_free    = r_is_free;
        n_status     = r_status;
        n_out_valid  = r_out_valid && !i_ready;
        n_granted    = r_granted;
        n_out_status = r_out_status;
        n_out_used   = r_out_used;
        n_out_free   = r_out_free;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_word[WAW-1:0];
        ram_wr_data  = '0;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = r_word[WAW-1:0];
        o_ready      = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_word[WAW-1:0];
                n_word      = r_word + WORD_W'(1);
                if (r_word == LAST_MEM_WORD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready   = 1'b1;
                n_is_free = (i_action == ACT_FREE);
                n_page    = req_page;
                if (i_valid) begin
                    if (i_action == ACT_ALLOC) begin
                        if (r_hint >= limit) begin
                            n_status = STAT_FULL;
                            n_state  = S_RESP;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = r_hint[BIT_W +: WAW];
                            n_word      = r_hint[PN_W-1:BIT_W];
                            n_state     = S_SCAN;
                        end
                    end else if (i_action == ACT_NONE) begin
                        n_status = STAT_NOCHANGE;
                        n_state  = S_RESP;
                    end else if (req_misaligned) begin
                        n_status = STAT_MISALIGNED;
                        n_state  = S_RESP;
                    end else if (req_out_range) begin
                        n_status = STAT_RANGE;
                        n_state  = S_RESP;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = req_page[BIT_W +: WAW];
                        n_state     = S_FR_CHK;
                    end
                end
            end
            S_SCAN: begin
                if (scan_found) begin
                    if (slot_free) begin
                        ram_wr_en    = 1'b1;
                        ram_wr_addr  = r_word[WAW-1:0];
                        ram_wr_data  = ram_rd_data | (MAP_BITS'(1) << scan_idx);
                        n_used       = r_used + PN_W'(1);
                        if (scan_page == r_hint) begin
                            n_hint = r_hint + PN_W'(1);
                        end
                        n_out_valid  = 1'b1;
                        n_granted    = grant_wide[GA_W-1:0];
                        n_out_status = STAT_DONE;
                        n_state      = S_IDLE;
                    end
                end else if (r_word >= limit_m1[PN_W-1:BIT_W]) begin
                    n_status = STAT_FULL;
                    n_state  = S_RESP;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = WAW'(r_word + WORD_W'(1));
                    n_word      = r_word + WORD_W'(1);
                end
            end
            S_FR_CHK: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_granted    = '0;
                    n_out_status = STAT_NOCHANGE;
                    ram_wr_addr  = r_page[BIT_W +: WAW];
                    if (r_is_free && fr_bit) begin
                        ram_wr_en    = 1'b1;
                        ram_wr_data  = ram_rd_data & ~(MAP_BITS'(1) << r_page[BIT_W-1:0]);
                        n_used       = r_used - PN_W'(1);
                        n_out_status = STAT_DONE;
                        if (r_page < r_hint) begin
                            n_hint = r_page;
                        end
                    end else if (!r_is_free && !fr_bit) begin
                        ram_wr_en    = 1'b1;
                        ram_wr_data  = ram_rd_data | (MAP_BITS'(1) << r_page[BIT_W-1:0]);
                        n_used       = r_used + PN_W'(1);
                        n_out_status = STAT_DONE;
                    end
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_granted    = '0;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Every response beat carries the counts after its step.
        n_out_used = n_used;
        n_out_free = (r_cfg_pages > n_used) ? (r_cfg_pages - n_used) : '0;
        if (!(n_out_valid && !(r_out_valid && !i_ready))) begin
            n_out_used = r_out_used;
            n_out_free = r_out_free;
        end
    end

    // State, counters, configuration and the response register.
    always_ff @(posedge i_clk) begin
        r_page       <= n_page;
        r_is_free    <= n_is_free;
        r_status     <= n_status;
        r_granted    <= n_granted;
        r_out_status <= n_out_status;
        r_out_used   <= n_out_used;
        r_out_free   <= n_out_free;
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_word      <= '0;
            r_used      <= '0;
            r_hint      <= '0;
            r_cfg_pages <= PN_W'(4096);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word      <= n_word;
            r_used      <= n_used;
            r_hint      <= n_hint;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_cfg_pages <= i_pages_in_use_range;
            end
        end
    end

    // Configuration beats are taken whenever reset is not held.
    assign o_cfg_ready       = i_rst_n;
    assign o_valid           = r_out_valid;
    assign o_granted_address = r_granted;
    assign o_status          = r_out_status;
    assign o_used_count      = r_out_used;
    assign o_free_count      = r_out_free;

endmodule

`default_nettype wire

// ===== sim/bitmap_page_frame_allocator_core_test.sv =====
// Self-checking testbench for the bitmap page frame allocator core.
// Drives all four actions and range writes; checks each response against a model or a typed row.
// Depends on bpfa_pkg and the allocator core RTL.
`default_nettype none

module bitmap_page_frame_allocator_core_test;
    import bpfa_pkg::*;

    localparam int unsigned FRAMES       = 4096;
    localparam int unsigned FRAME_BYTES  = 4096;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned NUM_ROWS     = 30;
    localparam int unsigned NUM_PHASES   = 8;

    // Page-range setting and item count of each random phase; the last phase runs without idling.
    localparam int unsigned PHASE_RANGE [NUM_PHASES] = '{40, 100, 33, 4096, 1, 64, 8191, 17};
    localparam int unsigned PHASE_ITEMS [NUM_PHASES] = '{250, 250, 150, 200, 100, 200, 150, 150};

    typedef struct packed {
        logic [GA_W-1:0] granted;
        t_status         status;
        logic [PN_W-1:0] used;
        logic [PN_W-1:0] free_pages;
    } t_frame_response;

    // One directed row: either a page-range write (value in addr) or a request beat.
    typedef struct packed {
        bit                is_cfg;
        t_action           act;
        logic [ADDR_W-1:0] addr;
        bit                typed;
        t_frame_response   want;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [PN_W-1:0]   i_pages_in_use_range = '0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [ACT_W-1:0]  i_action = '0;
    logic [ADDR_W-1:0] i_page_address = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [GA_W-1:0]   o_granted_address;
    logic [ST_W-1:0]   o_status;
    logic [PN_W-1:0]   o_used_count;
    logic [PN_W-1:0]   o_free_count;

    // Model of the allocator state.
    bit              frame_used [FRAMES];
    logic [PN_W-1:0] frames_used_total = '0;
    logic [PN_W-1:0] next_hint = '0;
    logic [PN_W-1:0] frame_range = PN_W'(4096);

    t_frame_response pending_responses [$];
    bit              idle_on = 1'b1;
    int unsigned     stall_left = 0;
    int unsigned     mismatches = 0;
    int unsigned     cycles = 0;
    int unsigned     requests_sent = 0;
    int unsigned     range_settings = 0;
    int unsigned     pages_granted = 0;
    int unsigned     full_refusals = 0;

    // Directed rows: typed expectations only after reset, at the extremes and for error codes.
    t_stim_row directed_rows [NUM_ROWS] = '{
        '{1'b0, ACT_ALLOC,   32'h0000_0000, 1'b1, '{24'h000000, STAT_DONE,       13'd1, 13'd4095}},
        '{1'b0, ACT_ALLOC,   32'h0000_0000, 1'b1, '{24'h001000, STAT_DONE,       13'd2, 13'd4094}},
        '{1'b0, ACT_FREE,    32'hFFFF_FFFF, 1'b1, '{24'h000000, STAT_MISALIGNED, 13'd2, 13'd4094}},
        '{1'b0, ACT_FREE,    32'hFFFF_F000, 1'b1, '{24'h000000, STAT_RANGE,      13'd2, 13'd4094}},
        '{1'b0, ACT_RESERVE, 32'h0100_0000, 1'b1, '{24'h000000, STAT_RANGE,      13'd2, 13'd4094}},
        '{1'b0, ACT_RESERVE, 32'h00FF_F000, 1'b1, '{24'h000000, STAT_DONE,       13'd3, 13'd4093}},
        '{1'b0, ACT_RESERVE, 32'h00FF_F000, 1'b1, '{24'h000000, STAT_NOCHANGE,   13'd3, 13'd4093}},
        '{1'b0, ACT_FREE,    32'h0000_5000, 1'b1, '{24'h000000, STAT_NOCHANGE,   13'd3, 13'd4093}},
        '{1'b0, ACT_NONE,    32'hFFFF_FFFF, 1'b1, '{24'h000000, STAT_NOCHANGE,   13'd3, 13'd4093}},
        '{1'b0, ACT_FREE,    32'h0000_0000, 1'b1, '{24'h000000, STAT_DONE,       13'd2, 13'd4094}},
        '{1'b0, ACT_ALLOC,   32'h0000_0000, 1'b1, '{24'h000000, STAT_DONE,       13'd3, 13'd4093}},
        '{1'b0, ACT_ALLOC,   32'hA5A5_A5A5, 1'b0, '0},
        '{1'b0, ACT_RESERVE, 32'h0000_3000, 1'b0, '0},
        '{1'b0, ACT_ALLOC,   32'h5A5A_5A5A, 1'b0, '0},
        '{1'b0, ACT_FREE,    32'h0000_1000, 1'b0, '0},
        '{1'b0, ACT_ALLOC,   32'h0000_0000, 1'b0, '0},
        '{1'b1, ACT_NONE,    32'd8,         1'b0, '0},
        '{1'b0, ACT_ALLOC,   32'h0000_0000, 1'b0, '0},
        '{1'b0, ACT_ALLOC,   32'h0000_0000, 1'b0, '0},
        '{1'b0, ACT_ALLOC,   32'h0000_0000, 1'b0, '0},
        '{1'b0, ACT_ALLOC,   32'h0000_0000, 1'b1, '{24'h000000, STAT_FULL,       13'd9, 13'd0}},
        '{1'b0, ACT_FREE,    32'h00FF_F000, 1'b1, '{24'h000000, STAT_RANGE,      13'd9, 13'd0}},
        '{1'b0, ACT_FREE,    32'h0000_7000, 1'b0, '0},
        '{1'b1, ACT_NONE,    32'd2,         1'b0, '0},
        '{1'b0, ACT_ALLOC,   32'h0000_0000, 1'b1, '{24'h000000, STAT_FULL,       13'd8, 13'd0}},
        '{1'b1, ACT_NONE,    32'd0,         1'b0, '0},
        '{1'b0, ACT_FREE,    32'h0000_0000, 1'b1, '{24'h000000, STAT_RANGE,      13'd8, 13'd0}},
        '{1'b1, ACT_NONE,    32'd8191,      1'b0, '0},
        '{1'b0, ACT_ALLOC,   32'h0000_0000, 1'b0, '0},
        '{1'b0, ACT_FREE,    32'h0000_7000, 1'b0, '0}
    };

    bitmap_page_frame_allocator_core #(
        .FRAME_COUNT (FRAMES),
        .PAGE_BYTES  (FRAME_BYTES)
    ) i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_pages_in_use_range (i_pages_in_use_range),
        .i_valid              (i_valid),
        .o_ready              (o_ready),
        .i_action             (i_action),
        .i_page_address       (i_page_address),
        .o_valid              (o_valid),
        .i_ready              (i_ready),
        .o_granted_address    (o_granted_address),
        .o_status             (o_status),
        .o_used_count         (o_used_count),
        .o_free_count         (o_free_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Work out the response to one request beat and advance the model state.
    function automatic t_frame_response predict_frame_response(input t_action act,
                                                               input logic [ADDR_W-1:0] addr);
        t_frame_response r;
        int unsigned     lim;
        int unsigned     pg;
        int unsigned     p;
        bit              found;
        lim = (frame_range > FRAMES) ? FRAMES : frame_range;
        r.granted = '0;
        r.status = STAT_NOCHANGE;
        found = 1'b0;
        case (act) inside
            ACT_ALLOC: begin
                // First clear bit at or above the hint; the hint moves only if it was hit.
                r.status = STAT_FULL;
                for (p = next_hint; p < lim && !found; p++) begin
                    if (!frame_used[p]) begin
                        frame_used[p] = 1'b1;
                        frames_used_total = frames_used_total + 1'b1;
                        if (p == next_hint) begin
                            next_hint = next_hint + 1'b1;
                        end
                        r.granted = GA_W'(p * FRAME_BYTES);
                        r.status = STAT_DONE;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    pages_granted++;
                end else begin
                    full_refusals++;
                end
            end
            ACT_FREE, ACT_RESERVE: begin
                pg = addr / FRAME_BYTES;
                if (addr % FRAME_BYTES != 0) begin
                    r.status = STAT_MISALIGNED;
                end else if (pg >= lim) begin
                    r.status = STAT_RANGE;
                end else if (act == ACT_FREE) begin
                    if (frame_used[pg]) begin
                        frame_used[pg] = 1'b0;
                        frames_used_total = frames_used_total - 1'b1;
                        if (pg < next_hint) begin
                            next_hint = PN_W'(pg);
                        end
                        r.status = STAT_DONE;
                    end
                end else if (!frame_used[pg]) begin
                    frame_used[pg] = 1'b1;
                    frames_used_total = frames_used_total + 1'b1;
                    r.status = STAT_DONE;
                end
            end
            default: begin
            end
        endcase
        r.used = frames_used_total;
        r.free_pages = (frame_range > frames_used_total) ? frame_range - frames_used_total : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH at cycle %0d, %s: got 0x%0h, expected 0x%0h", cycles, what, got, want);
        mismatches++;
    endtask

    // Present one request beat, with an optional random gap first, and record its expected response.
    task automatic send_request(input t_action act, input logic [ADDR_W-1:0] addr,
                                input bit typed, input t_frame_response want);
        t_frame_response predicted;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_page_address <= addr;
        do @(posedge i_clk); while (!o_ready);
        predicted = predict_frame_response(act, addr);
        pending_responses.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    // Write the page range once every outstanding response has come back.
    task automatic configure_range(input logic [PN_W-1:0] value);
        i_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_pages_in_use_range <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        frame_range = value;
        range_settings++;
        i_cfg_valid <= 1'b0;
    endtask

    // Response checking, plus random stall bursts on the response channel.
    always @(posedge i_clk) begin : response_check
        t_frame_response want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("response beat with nothing pending", 32'(o_status), 32'd0);
            end else begin
                want = pending_responses.pop_front();
                if (o_granted_address !== want.granted) begin
                    report_mismatch("granted address", 32'(o_granted_address),
                                    32'(want.granted));
                end
                if (o_status !== want.status) begin
                    report_mismatch("status", 32'(o_status), 32'(want.status));
                end
                if (o_used_count !== want.used) begin
                    report_mismatch("used count", 32'(o_used_count), 32'(want.used));
                end
                if (o_free_count !== want.free_pages) begin
                    report_mismatch("free count", 32'(o_free_count), 32'(want.free_pages));
                end
            end
        end
        if (stall_left != 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            i_ready <= 1'b0;
            stall_left <= $urandom_range(0, 8);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int unsigned       phase;
        int unsigned       k;
        int unsigned       pick;
        int unsigned       span;
        int unsigned       pg;
        t_action           act;
        logic [ADDR_W-1:0] addr;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows.
        for (k = 0; k < NUM_ROWS; k++) begin
            if (directed_rows[k].is_cfg) begin
                configure_range(directed_rows[k].addr[PN_W-1:0]);
            end else begin
                send_request(directed_rows[k].act, directed_rows[k].addr,
                             directed_rows[k].typed, directed_rows[k].want);
            end
        end

        // Random phases, each under its own page range.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            configure_range(PN_W'(PHASE_RANGE[phase]));
            if (phase == NUM_PHASES - 1) begin
                idle_on = 1'b0;
            end
            span = (PHASE_RANGE[phase] > FRAMES) ? FRAMES : PHASE_RANGE[phase];
            for (k = 0; k < PHASE_ITEMS[phase]; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    act = ACT_ALLOC;
                end else if (pick < 75) begin
                    act = ACT_FREE;
                end else if (pick < 88) begin
                    act = ACT_RESERVE;
                end else begin
                    act = ACT_NONE;
                end
                // Mostly aligned pages near the range, some misaligned or wild addresses.
                pg = $urandom_range(0, span + 3);
                pick = $urandom_range(0, 9);
                if (act == ACT_ALLOC || act == ACT_NONE || pick == 8) begin
                    addr = $urandom();
                end else if (pick == 9) begin
                    addr = pg * FRAME_BYTES + $urandom_range(1, FRAME_BYTES - 1);
                end else begin
                    addr = pg * FRAME_BYTES;
                end
                send_request(act, addr, 1'b0, '0);
            end
        end

        i_valid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_responses.size() != 0) begin
            report_mismatch("responses still owed at end", 32'(pending_responses.size()),
                            32'd0);
        end

        $display("Ran %0d requests under %0d page-range settings with stalls on both sides.",
                 requests_sent, range_settings);
        $display("Allocations granted %0d pages and were refused %0d times for lack of space.",
                 pages_granted, full_refusals);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== bitmap_page_frame_allocator_core.f =====
design/bpfa_pkg.sv
design/bpfa_ram.sv
design/bitmap_page_frame_allocator_core.sv
sim/bitmap_page_frame_allocator_core_test.sv
